// ===== src/fog_volume_first_match_top_assert.svh =====
// Assertion macros for the fog volume first match block.
// Used by modules that have clk and rst in scope; define NO_ASSERTIONS to drop them.
`ifndef FOG_VOLUME_FIRST_MATCH_TOP_ASSERT_SVH
`define FOG_VOLUME_FIRST_MATCH_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FVFM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fvfm assertion failed");
`define FVFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fvfm assertion failed");
`else
`define FVFM_ASSERT_SAME(lbl, ante, cons)
`define FVFM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/fvfm_pkg.sv =====
// Package for the fog volume first match block: widths, codes, box and bound types.
// No dependencies; the interfaces and modules of the block use it by scoped names.
`timescale 1ns / 1ps

package fvfm_pkg;

  localparam int MAX_FOG_ENTRIES = 256;
  localparam int COORD_W         = 32;
  localparam int BOUND_W         = COORD_W + 2;
  localparam int RAD_W           = 31;
  localparam int IDX_W           = 8;
  localparam int CNT_W           = 9;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [BOUND_W-1:0] bound_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  // Sphere extent on each axis: centre minus and plus radius
  typedef struct packed {
    bound_t lo_x;
    bound_t hi_x;
    bound_t lo_y;
    bound_t hi_y;
    bound_t lo_z;
    bound_t hi_z;
  } bounds_t;

  // Sign-extend a coordinate to bound width
  function automatic bound_t ext_coord(coord_t v);
    return {{(BOUND_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  // Add two coordinates, clamping to the signed 32-bit range
  function automatic coord_t sat_add(coord_t a, coord_t b);
    logic [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return s[COORD_W-1:0];
  endfunction

endpackage

// ===== src/fvfm_if.sv =====
// Request and response channel interfaces for the fog volume first match block.
// Depends on fvfm_pkg for field widths.
`timescale 1ns / 1ps

interface fvfm_req_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [fvfm_pkg::IDX_W-1:0] entry_index;
  fvfm_pkg::coord_t          pos_x;
  fvfm_pkg::coord_t          pos_y;
  fvfm_pkg::coord_t          pos_z;
  fvfm_pkg::coord_t          ext_x;
  fvfm_pkg::coord_t          ext_y;
  fvfm_pkg::coord_t          ext_z;
  logic [fvfm_pkg::RAD_W-1:0] radius;
  logic                      no_world;

  modport source (output valid, opcode, entry_index, pos_x, pos_y, pos_z,
                  ext_x, ext_y, ext_z, radius, no_world, input ready);
  modport sink   (input valid, opcode, entry_index, pos_x, pos_y, pos_z,
                  ext_x, ext_y, ext_z, radius, no_world, output ready);
endinterface

interface fvfm_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [fvfm_pkg::IDX_W-1:0] fog_number;

  modport source (output valid, fog_number, input ready);
  modport sink   (input valid, fog_number, output ready);
endinterface

// ===== src/fvfm_table.sv =====
// Fog box table: one write port, one registered read port.
// Depends on fvfm_pkg for the box type.
`timescale 1ns / 1ps

module fvfm_table #(
  parameter int DEPTH = fvfm_pkg::MAX_FOG_ENTRIES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  fvfm_pkg::box_t           wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output fvfm_pkg::box_t           rd_data
);

  fvfm_pkg::box_t mem [DEPTH];

  // Store a loaded box
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry per cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/fvfm_overlap.sv =====
// Sphere-box overlap test, shared by every entry of a scan.
// Depends on fvfm_pkg for the bound and box types.
`timescale 1ns / 1ps

module fvfm_overlap (
  input  fvfm_pkg::bounds_t bnd,
  input  fvfm_pkg::box_t    box,
  output logic              hit
);

  logic hit_x, hit_y, hit_z;

  // Overlap on an axis: low end below box max and high end above box min
  assign hit_x = (bnd.lo_x < fvfm_pkg::ext_coord(box.max_x)) &&
                 (bnd.hi_x > fvfm_pkg::ext_coord(box.min_x));
  assign hit_y = (bnd.lo_y < fvfm_pkg::ext_coord(box.max_y)) &&
                 (bnd.hi_y > fvfm_pkg::ext_coord(box.min_y));
  assign hit_z = (bnd.lo_z < fvfm_pkg::ext_coord(box.max_z)) &&
                 (bnd.hi_z > fvfm_pkg::ext_coord(box.min_z));

  assign hit = hit_x && hit_y && hit_z;

endmodule

// ===== src/fvfm_seq.sv =====
// Sequencer: takes requests, loads the table, scans it for a query, holds the result.
// Depends on fvfm_pkg, fvfm_if and the assertion macro header.
`timescale 1ns / 1ps
`include "fog_volume_first_match_top_assert.svh"

module fvfm_seq #(
  parameter int MAX_FOG_ENTRIES = fvfm_pkg::MAX_FOG_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst,
  fvfm_req_if.sink                           req,
  fvfm_rsp_if.source                         rsp,
  input  logic                               cfg_we,
  input  logic [fvfm_pkg::CNT_W-1:0]         cfg_data,
  output logic                               tbl_we,
  output logic [$clog2(MAX_FOG_ENTRIES)-1:0] tbl_wr_addr,
  output fvfm_pkg::box_t                     tbl_wr_data,
  output logic [$clog2(MAX_FOG_ENTRIES)-1:0] tbl_rd_addr,
  output fvfm_pkg::bounds_t                  bnd,
  input  logic                               hit
);

  localparam int AW    = $clog2(MAX_FOG_ENTRIES);
  localparam int LIM_W = ($clog2(MAX_FOG_ENTRIES + 1) > fvfm_pkg::CNT_W) ?
                         $clog2(MAX_FOG_ENTRIES + 1) : fvfm_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BOUND = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                     state, state_next;
  logic [fvfm_pkg::CNT_W-1:0] fog_count;
  fvfm_pkg::coord_t           cx, cy, cz;
  logic [fvfm_pkg::RAD_W-1:0] rad;
  logic [LIM_W-1:0]           limit_r;
  logic [LIM_W-1:0]           ptr;
  logic                       rd_vld;
  logic [LIM_W-1:0]           rd_idx;
  logic [fvfm_pkg::IDX_W-1:0] result;
  logic                       out_valid;
  logic [fvfm_pkg::IDX_W-1:0] out_num;

  logic             accept;
  logic             is_query;
  logic             issue;
  logic             found;
  logic             scan_empty;
  logic             out_load;
  logic [LIM_W-1:0] idx_ext;
  logic [LIM_W-1:0] count_ext;
  logic [LIM_W-1:0] max_ext;
  fvfm_pkg::bound_t rad_ext;

  assign accept     = req.valid && req.ready;
  assign is_query   = (req.opcode == fvfm_pkg::OP_QUERY);
  assign issue      = (state == S_SCAN) && (ptr < limit_r);
  assign found      = (state == S_SCAN) && rd_vld && hit;
  assign scan_empty = (state == S_SCAN) && !issue && !rd_vld;
  assign out_load   = (state == S_DONE) && (!out_valid || rsp.ready);
  assign idx_ext    = LIM_W'(req.entry_index);
  assign count_ext  = LIM_W'(fog_count);
  assign max_ext    = LIM_W'(MAX_FOG_ENTRIES);
  assign rad_ext    = fvfm_pkg::bound_t'({{(fvfm_pkg::BOUND_W-fvfm_pkg::RAD_W){1'b0}}, rad});

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.fog_number = out_num;

  // Table write from a load request
  assign tbl_we      = accept && !is_query && (idx_ext < max_ext);
  assign tbl_wr_addr = idx_ext[AW-1:0];
  assign tbl_wr_data = '{min_x: req.pos_x, min_y: req.pos_y, min_z: req.pos_z,
                         max_x: req.ext_x, max_y: req.ext_y, max_z: req.ext_z};
  assign tbl_rd_addr = ptr[AW-1:0];

  // Pick the next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && is_query) begin
          state_next = req.no_world ? S_DONE : S_BOUND;
        end
      end
      S_BOUND: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (found || scan_empty) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fog_count <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue && !found;
      if (cfg_we) begin
        fog_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Query operands, scan pointer and result
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      cx      <= fvfm_pkg::sat_add(req.pos_x, req.ext_x);
      cy      <= fvfm_pkg::sat_add(req.pos_y, req.ext_y);
      cz      <= fvfm_pkg::sat_add(req.pos_z, req.ext_z);
      rad     <= req.radius;
      limit_r <= (count_ext > max_ext) ? max_ext : count_ext;
      result  <= '0;
    end
    if (state == S_BOUND) begin
      bnd.lo_x <= fvfm_pkg::ext_coord(cx) - rad_ext;
      bnd.hi_x <= fvfm_pkg::ext_coord(cx) + rad_ext;
      bnd.lo_y <= fvfm_pkg::ext_coord(cy) - rad_ext;
      bnd.hi_y <= fvfm_pkg::ext_coord(cy) + rad_ext;
      bnd.lo_z <= fvfm_pkg::ext_coord(cz) - rad_ext;
      bnd.hi_z <= fvfm_pkg::ext_coord(cz) + rad_ext;
      ptr      <= LIM_W'(1);
    end else if (issue) begin
      ptr <= ptr + LIM_W'(1);
    end
    rd_idx <= ptr;
    if (found) begin
      result <= rd_idx[fvfm_pkg::IDX_W-1:0];
    end
    if (out_load) begin
      out_num <= result;
    end
  end

  `FVFM_ASSERT_SAME(a_rdvld_in_scan, rd_vld, state == S_SCAN)
  `FVFM_ASSERT_SAME(a_rdidx_range, rd_vld, (rd_idx != '0) && (rd_idx < limit_r))
  `FVFM_ASSERT_NEXT(a_query_busy, accept && is_query, state != S_IDLE)
  `FVFM_ASSERT_NEXT(a_result_shown, out_load, out_valid)

endmodule

// ===== src/fog_volume_first_match_top.sv =====
// Fog volume first match: a table of fog boxes that loads fill and queries scan
// for the first box that a sphere overlaps, 0 when none. A load gives no
// response. A query with no_world set skips the scan and answers 0 through the
// done state. Any other query registers the sphere bounds in the bound state,
// then scans entries 1 to N-1, with N = min(fog_count, MAX_FOG_ENTRIES).
// The scan reads one table entry per cycle through the single table read port
// and tests it in one shared overlap unit, stopping at the first match. With
// no match the response is 0. In the done state the result is loaded into the
// output register once that register is free; a response still waiting there
// stalls the query. The block turns ready again in the cycle the response
// shows. No request is taken while a query is in progress. The response waits
// in an output register, so a new request is taken while it is still pending.
// Table entries hold no value after reset until loaded; fog_count resets to 0.
`timescale 1ns / 1ps

module fog_volume_first_match_top #(
  parameter int MAX_FOG_ENTRIES = fvfm_pkg::MAX_FOG_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  fvfm_req_if.sink                   req,
  fvfm_rsp_if.source                 rsp,
  input  logic                       cfg_we,
  input  logic [fvfm_pkg::CNT_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_FOG_ENTRIES);

  logic              tbl_we;
  logic [AW-1:0]     tbl_wr_addr;
  fvfm_pkg::box_t    tbl_wr_data;
  logic [AW-1:0]     tbl_rd_addr;
  fvfm_pkg::box_t    tbl_rd_data;
  fvfm_pkg::bounds_t bnd;
  logic              hit;

  // Sequencer
  fvfm_seq #(
    .MAX_FOG_ENTRIES(MAX_FOG_ENTRIES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .tbl_we     (tbl_we),
    .tbl_wr_addr(tbl_wr_addr),
    .tbl_wr_data(tbl_wr_data),
    .tbl_rd_addr(tbl_rd_addr),
    .bnd        (bnd),
    .hit        (hit)
  );

  // Box table
  fvfm_table #(
    .DEPTH(MAX_FOG_ENTRIES)
  ) u_table (
    .clk    (clk),
    .we     (tbl_we),
    .wr_addr(tbl_wr_addr),
    .wr_data(tbl_wr_data),
    .rd_addr(tbl_rd_addr),
    .rd_data(tbl_rd_data)
  );

  // Shared overlap test
  fvfm_overlap u_overlap (
    .bnd(bnd),
    .box(tbl_rd_data),
    .hit(hit)
  );

endmodule

// ===== test/fog_volume_first_match_top_test.sv =====
// Testbench for fog_volume_first_match_top: loads fog boxes, scans spheres against them
// and checks every fog_number against a behavioral predictor kept in a scoreboard class.
// Depends on fvfm_pkg, fvfm_if (request and response interfaces) and the block itself.
`timescale 1ns / 1ps

module fog_volume_first_match_top_test;
  import fvfm_pkg::*;

  localparam int     LIMIT_CYCLES = 1_000_000;
  localparam int     DRAIN_CYCLES = 16;
  localparam int     PHASE_ITEMS  = 28;
  localparam longint C32_HI       = 64'sh0000_0000_7FFF_FFFF;
  localparam longint C32_LO       = -64'sh0000_0000_8000_0000;
  localparam coord_t C_MAX        = 32'sh7FFF_FFFF;
  localparam coord_t C_MIN        = 32'sh8000_0000;
  localparam logic [RAD_W-1:0] R_MAX = '1;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] entry_index;
    coord_t           pos_x;
    coord_t           pos_y;
    coord_t           pos_z;
    coord_t           ext_x;
    coord_t           ext_y;
    coord_t           ext_z;
    logic [RAD_W-1:0] radius;
    logic             no_world;
  } fog_request_t;

  // Shadow fog table plus the queue of fog numbers still owed by the block
  class fog_match_tracker;
    coord_t           lo_x[MAX_FOG_ENTRIES];
    coord_t           lo_y[MAX_FOG_ENTRIES];
    coord_t           lo_z[MAX_FOG_ENTRIES];
    coord_t           hi_x[MAX_FOG_ENTRIES];
    coord_t           hi_y[MAX_FOG_ENTRIES];
    coord_t           hi_z[MAX_FOG_ENTRIES];
    int unsigned      fog_count;
    logic [IDX_W-1:0] fog_numbers_due[$];

    function new();
      fog_count = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      fog_count = v;
    endfunction

    // Clamp origin plus offset to the signed 32-bit range
    function longint centre(coord_t a, coord_t b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > C32_HI) return C32_HI;
      if (s < C32_LO) return C32_LO;
      return s;
    endfunction

    function bit axis_hit(longint c, longint r, coord_t lo, coord_t hi);
      return (c - r < longint'(hi)) && (c + r > longint'(lo));
    endfunction

    // Scan entries from 1 upward; entry 0 never matches
    function logic [IDX_W-1:0] first_overlap(fog_request_t q);
      longint cx, cy, cz, r;
      int     lim;
      if (q.no_world) return '0;
      cx  = centre(q.pos_x, q.ext_x);
      cy  = centre(q.pos_y, q.ext_y);
      cz  = centre(q.pos_z, q.ext_z);
      r   = longint'(q.radius);
      lim = (fog_count > MAX_FOG_ENTRIES) ? MAX_FOG_ENTRIES : int'(fog_count);
      for (int i = 1; i < lim; i++) begin
        if (axis_hit(cx, r, lo_x[i], hi_x[i]) && axis_hit(cy, r, lo_y[i], hi_y[i]) &&
            axis_hit(cz, r, lo_z[i], hi_z[i])) begin
          return IDX_W'(i);
        end
      end
      return '0;
    endfunction

    function void note_request(fog_request_t q);
      if (q.opcode == OP_LOAD) begin
        lo_x[q.entry_index] = q.pos_x;
        lo_y[q.entry_index] = q.pos_y;
        lo_z[q.entry_index] = q.pos_z;
        hi_x[q.entry_index] = q.ext_x;
        hi_y[q.entry_index] = q.ext_y;
        hi_z[q.entry_index] = q.ext_z;
      end else begin
        fog_numbers_due.push_back(first_overlap(q));
      end
    endfunction

    function bit check_result(logic [IDX_W-1:0] got, output string why);
      logic [IDX_W-1:0] want;
      if (fog_numbers_due.size() == 0) begin
        why = $sformatf("fog_number %0d arrived with no query outstanding", got);
        return 0;
      end
      want = fog_numbers_due.pop_front();
      if (got !== want) begin
        why = $sformatf("fog_number %0d, expected %0d", got, want);
        return 0;
      end
      return 1;
    endfunction

    function int pending();
      return fog_numbers_due.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;

  fvfm_req_if req_ch();
  fvfm_rsp_if rsp_ch();

  fog_volume_first_match_top dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  fog_match_tracker tracker = new();
  int errors         = 0;
  int loads_sent     = 0;
  int queries_sent   = 0;
  int hits           = 0;
  int settings_used  = 0;
  bit no_stall       = 0;

  // Clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(string why);
    errors++;
    $display("%0t ns: %s", $time, why);
  endtask

  function automatic int pick_gap();
    return no_stall ? 0 : $urandom_range(0, 8);
  endfunction

  // Drive one request and hold it until the block takes it
  task automatic send_request(fog_request_t q);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.opcode      = q.opcode;
    req_ch.entry_index = q.entry_index;
    req_ch.pos_x       = q.pos_x;
    req_ch.pos_y       = q.pos_y;
    req_ch.pos_z       = q.pos_z;
    req_ch.ext_x       = q.ext_x;
    req_ch.ext_y       = q.ext_y;
    req_ch.ext_z       = q.ext_z;
    req_ch.radius      = q.radius;
    req_ch.no_world    = q.no_world;
    req_ch.valid       = 1'b1;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    tracker.note_request(q);
    if (q.opcode == OP_LOAD) loads_sent++;
    else queries_sent++;
  endtask

  // Drop valid and wait until every owed fog number is back
  task automatic settle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_fog_count(logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we   = 1'b0;
    tracker.set_count(v);
    settings_used++;
  endtask

  function automatic fog_request_t fixed_box(logic [IDX_W-1:0] idx, coord_t lo, coord_t hi);
    fog_request_t q;
    q.opcode      = OP_LOAD;
    q.entry_index = idx;
    q.pos_x       = lo;
    q.pos_y       = lo;
    q.pos_z       = lo;
    q.ext_x       = hi;
    q.ext_y       = hi;
    q.ext_z       = hi;
    q.radius      = RAD_W'($urandom);
    q.no_world    = 1'($urandom_range(0, 1));
    return q;
  endfunction

  function automatic fog_request_t sphere(coord_t px, coord_t pyz, coord_t e,
                                          logic [RAD_W-1:0] r, logic nw);
    fog_request_t q;
    q.opcode      = OP_QUERY;
    q.entry_index = IDX_W'($urandom);
    q.pos_x       = px;
    q.pos_y       = pyz;
    q.pos_z       = pyz;
    q.ext_x       = e;
    q.ext_y       = e;
    q.ext_z       = e;
    q.radius      = r;
    q.no_world    = nw;
    return q;
  endfunction

  // Random box: mostly compact, sometimes inverted, sometimes fully random
  function automatic fog_request_t box_item(logic [IDX_W-1:0] idx);
    fog_request_t q;
    int           mode, c, h;
    coord_t       lo[3];
    coord_t       hi[3];
    coord_t       t;
    mode = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      if (mode == 9) begin
        lo[a] = coord_t'($urandom);
        hi[a] = coord_t'($urandom);
      end else begin
        c     = int'($urandom_range(0, 1 << 24)) - (1 << 23);
        h     = int'($urandom_range(1, 1 << 18));
        lo[a] = coord_t'(c - h);
        hi[a] = coord_t'(c + h);
        if (mode == 8) begin
          t     = lo[a];
          lo[a] = hi[a];
          hi[a] = t;
        end
      end
    end
    q.opcode      = OP_LOAD;
    q.entry_index = idx;
    q.pos_x       = lo[0];
    q.pos_y       = lo[1];
    q.pos_z       = lo[2];
    q.ext_x       = hi[0];
    q.ext_y       = hi[1];
    q.ext_z       = hi[2];
    q.radius      = RAD_W'($urandom);
    q.no_world    = 1'($urandom_range(0, 1));
    return q;
  endfunction

  // Place a centre inside [lo, hi) and split it into origin plus offset
  function automatic void aim_axis(input coord_t lo, input coord_t hi,
                                   output coord_t pos, output coord_t ext);
    longint span, p, e;
    span = longint'(hi) - longint'(lo);
    p    = longint'(lo);
    if (span > 0) p = p + longint'($urandom) % span;
    e = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    if (p - e > C32_HI || p - e < C32_LO) e = 0;
    pos = coord_t'(p - e);
    ext = coord_t'(e);
  endfunction

  // Origin and offset of the same sign and large magnitude, so the sum clamps
  function automatic void big_pair(output coord_t pos, output coord_t ext);
    logic s;
    s   = 1'($urandom_range(0, 1));
    pos = {s, ~s, 30'($urandom)};
    ext = {s, ~s, 30'($urandom)};
  endfunction

  function automatic fog_request_t random_item(int lim);
    fog_request_t q;
    int           pick, tgt;
    pick = $urandom_range(0, 99);
    if (pick < 25) return box_item(IDX_W'($urandom));
    q.opcode      = OP_QUERY;
    q.entry_index = IDX_W'($urandom);
    q.radius      = RAD_W'($urandom_range(0, 1 << 12));
    q.no_world    = 1'b0;
    if (pick < 70 || pick >= 93) begin
      tgt = (lim >= 2) ? $urandom_range(1, lim - 1) : $urandom_range(0, MAX_FOG_ENTRIES - 1);
      aim_axis(tracker.lo_x[tgt], tracker.hi_x[tgt], q.pos_x, q.ext_x);
      aim_axis(tracker.lo_y[tgt], tracker.hi_y[tgt], q.pos_y, q.ext_y);
      aim_axis(tracker.lo_z[tgt], tracker.hi_z[tgt], q.pos_z, q.ext_z);
      q.no_world = (pick >= 93);
    end else if (pick < 85) begin
      q.pos_x    = coord_t'($urandom);
      q.pos_y    = coord_t'($urandom);
      q.pos_z    = coord_t'($urandom);
      q.ext_x    = coord_t'($urandom);
      q.ext_y    = coord_t'($urandom);
      q.ext_z    = coord_t'($urandom);
      q.radius   = RAD_W'($urandom);
      q.no_world = 1'($urandom_range(0, 1));
    end else begin
      big_pair(q.pos_x, q.ext_x);
      big_pair(q.pos_y, q.ext_y);
      big_pair(q.pos_z, q.ext_z);
      q.radius = RAD_W'($urandom);
    end
    return q;
  endfunction

  // Response side: stall at random, check every fog number taken
  initial begin
    int    gap;
    string why;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      @(posedge clk);
      while (rsp_ch.valid !== 1'b1) @(posedge clk);
      if (!tracker.check_result(rsp_ch.fog_number, why)) report_mismatch(why);
      else if (rsp_ch.fog_number != 0) hits++;
      @(negedge clk);
    end
  end

  // Cycle limit
  initial begin
    int cycles;
    for (cycles = 0; cycles < LIMIT_CYCLES; cycles++) @(posedge clk);
    $display("Run stopped after %0d cycles, %0d results outstanding", cycles,
             tracker.pending());
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned phase_counts[9];
    int          lim;
    req_ch.valid       = 1'b0;
    req_ch.opcode      = OP_LOAD;
    req_ch.entry_index = '0;
    req_ch.pos_x       = '0;
    req_ch.pos_y       = '0;
    req_ch.pos_z       = '0;
    req_ch.ext_x       = '0;
    req_ch.ext_y       = '0;
    req_ch.ext_z       = '0;
    req_ch.radius      = '0;
    req_ch.no_world    = 1'b0;
    rsp_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    rst                = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty table: counts of 0 and 1 scan nothing
    send_request(sphere(32'sd1050, 32'sd1050, 32'sd0, 31'd5, 1'b0));
    settle();
    write_fog_count(CNT_W'(1));
    send_request(sphere(32'sd1050, 32'sd1050, 32'sd0, 31'd5, 1'b0));

    // Hand-built boxes: entry 0 covers everything, 3 is inverted, 2 and 4 sit at the edges
    send_request(fixed_box(8'd0, C_MIN, C_MAX));
    send_request(fixed_box(8'd1, 32'sd1000, 32'sd1100));
    send_request(fixed_box(8'd2, 32'sh7FFF_FF00, C_MAX));
    send_request(fixed_box(8'd3, 32'sd500, -32'sd500));
    send_request(fixed_box(8'd4, C_MIN, C_MIN + 32'sd256));
    send_request(fixed_box(8'd255, -32'sd77, 32'sd4000));
    settle();
    write_fog_count(CNT_W'(5));

    send_request(sphere(32'sd1050, 32'sd1050, 32'sd0, 31'd0, 1'b0));
    send_request(sphere(32'sd1050, 32'sd1050, 32'sd0, 31'd0, 1'b1));
    send_request(sphere(32'sd2000, 32'sd2000, -32'sd950, 31'd0, 1'b0));
    // Touching the max or min face exactly is not an overlap
    send_request(sphere(32'sd1100, 32'sd1050, 32'sd0, 31'd0, 1'b0));
    send_request(sphere(32'sd1100, 32'sd1050, 32'sd0, 31'd1, 1'b0));
    send_request(sphere(32'sd1000, 32'sd1000, 32'sd0, 31'd0, 1'b0));
    // Centre clamps at both ends of the range
    send_request(sphere(C_MAX, C_MAX, C_MAX, 31'd1, 1'b0));
    send_request(sphere(C_MIN, C_MIN, C_MIN, 31'd1, 1'b0));
    // Largest radius around extreme centres
    send_request(sphere(C_MAX, C_MAX, 32'sd0, R_MAX, 1'b0));
    send_request(sphere(C_MIN, C_MIN, 32'sd0, R_MAX, 1'b0));
    // Inverted box needs a radius past its half-gap
    send_request(sphere(32'sd0, 32'sd0, 32'sd0, 31'd600, 1'b0));
    send_request(sphere(32'sd0, 32'sd0, 32'sd0, 31'd500, 1'b0));

    // Fill the whole table, with a few random items, mostly queries against the first entries, mixed in
    for (int i = 0; i < MAX_FOG_ENTRIES; i++) begin
      if ($urandom_range(0, 99) < 15) send_request(random_item(5));
      send_request(box_item(IDX_W'(i)));
    end

    // Phases over several counts, extremes and the clamped range included
    phase_counts = '{256, 2, 511, 37, 300, 1, 0, 0, 130};
    phase_counts[7] = $urandom_range(2, 511);
    for (int p = 0; p < 9; p++) begin
      settle();
      write_fog_count(CNT_W'(phase_counts[p]));
      no_stall = (p % 3 == 1);
      lim = (phase_counts[p] > MAX_FOG_ENTRIES) ? MAX_FOG_ENTRIES : int'(phase_counts[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Hold off once mid-phase until the block has answered everything
        if (p == 0 && k == PHASE_ITEMS / 2) settle();
        send_request(random_item(lim));
      end
    end
    no_stall = 0;
    settle();

    $display("Sent %0d fog box loads and %0d sphere queries over %0d fog_count settings.",
             loads_sent, queries_sent, settings_used);
    $display("%0d queries hit a fog box; %0d mismatches seen.", hits, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
